// ----- rtl/sts_pkg.sv -----
// ----------------------------------------------------------------------------
// sts_pkg
// Types, token kinds and character helpers for the SQL token scanner.
// ----------------------------------------------------------------------------
`default_nettype none
package sts_pkg;

  // one input beat
  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_input;
  } in_t;

  // one result beat
  typedef struct packed {
    logic [5:0]  token_kind;
    logic [31:0] start_offset;
    logic [15:0] token_length;
    logic        last_of_run;
  } out_t;

  typedef enum logic [3:0] {
    M_IDLE, M_PUNCT, M_COMMENT, M_IDENT, M_ZERO, M_INT, M_FRAC,
    M_EXPSIGN, M_EXPDIG, M_STR, M_STRESC, M_DATE, M_INSTR
  } mode_t;

  typedef enum logic [2:0] {
    P_NONE, P_MINUS, P_DOT, P_LT, P_GT, P_BANG
  } pend_t;

  typedef enum logic [1:0] {
    B_OCT, B_DEC, B_HEX
  } base_t;

  // control state of the scanner
  typedef struct packed {
    mode_t      mode;
    pend_t      pend;
    logic       ident_d;
    base_t      base_is;
    base_t      base_has;
    logic       empty;
    logic       flt;
    logic       inv;
    logic [4:0] dstep;
    logic       dt;
  } ctl_t;

  // token kinds
  localparam logic [5:0] K_EOF      = 6'd0;
  localparam logic [5:0] K_ILLEGAL  = 6'd1;
  localparam logic [5:0] K_BADNUM   = 6'd2;
  localparam logic [5:0] K_UNTSTR   = 6'd3;
  localparam logic [5:0] K_BADESC   = 6'd4;
  localparam logic [5:0] K_UNTDATE  = 6'd5;
  localparam logic [5:0] K_BADDATE  = 6'd6;
  localparam logic [5:0] K_IDENT    = 6'd7;
  localparam logic [5:0] K_OCT      = 6'd8;
  localparam logic [5:0] K_DEC      = 6'd9;
  localparam logic [5:0] K_HEX      = 6'd10;
  localparam logic [5:0] K_DFLOAT   = 6'd11;
  localparam logic [5:0] K_HFLOAT   = 6'd12;
  localparam logic [5:0] K_STRING   = 6'd13;
  localparam logic [5:0] K_DATE     = 6'd14;
  localparam logic [5:0] K_DATETIME = 6'd15;
  localparam logic [5:0] K_INSTR    = 6'd16;
  localparam logic [5:0] K_LPAREN   = 6'd17;
  localparam logic [5:0] K_RPAREN   = 6'd18;
  localparam logic [5:0] K_TILDE    = 6'd19;
  localparam logic [5:0] K_PLUS     = 6'd20;
  localparam logic [5:0] K_MINUS    = 6'd21;
  localparam logic [5:0] K_STAR     = 6'd22;
  localparam logic [5:0] K_SLASH    = 6'd23;
  localparam logic [5:0] K_PERCENT  = 6'd24;
  localparam logic [5:0] K_EQ       = 6'd25;
  localparam logic [5:0] K_NE       = 6'd26;
  localparam logic [5:0] K_LT       = 6'd27;
  localparam logic [5:0] K_LE       = 6'd28;
  localparam logic [5:0] K_GT       = 6'd29;
  localparam logic [5:0] K_GE       = 6'd30;
  localparam logic [5:0] K_COMMA    = 6'd31;
  localparam logic [5:0] K_SEMI     = 6'd32;
  localparam logic [5:0] K_DOT      = 6'd33;
  localparam logic [5:0] K_DOTDOT   = 6'd34;

  // date pattern slot classes
  localparam logic [2:0] S_OPTDASH = 3'd0;
  localparam logic [2:0] S_DIGIT   = 3'd1;
  localparam logic [2:0] S_DASH    = 3'd2;
  localparam logic [2:0] S_COLON   = 3'd3;
  localparam logic [2:0] S_SPACE   = 3'd4;
  localparam logic [2:0] S_CLOSE   = 3'd5;
  localparam int DATE_SLOTS  = 21;
  localparam int DATE_SPLIT  = 11;
  localparam logic [4:0] DATE_CLOSE = 5'd20;

  localparam int FIFO_DEPTH = 4;

  function automatic logic [2:0] date_slot(input logic [4:0] idx);
    case (idx)
      5'd0:                             date_slot = S_OPTDASH;
      5'd5, 5'd8:                       date_slot = S_DASH;
      5'd11:                            date_slot = S_SPACE;
      5'd14, 5'd17:                     date_slot = S_COLON;
      5'd1, 5'd2, 5'd3, 5'd4, 5'd6, 5'd7, 5'd9, 5'd10, 5'd12, 5'd13,
      5'd15, 5'd16, 5'd18, 5'd19:       date_slot = S_DIGIT;
      default:                          date_slot = S_CLOSE;
    endcase
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    is_dec = (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    is_oct = (c >= "0") && (c <= "7");
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = is_dec(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
  endfunction

endpackage
`default_nettype wire

// ----- rtl/sql_token_scanner.sv -----
// Path: a byte's tokens pass through the input register and then the result queue.
// Throughput: one input beat per cycle while each beat closes at most one
// token and out_ready stays high; the single result port drains one token per cycle from a 4-deep queue.
// Reset (rst_n low, synchronous): scanner idle between tokens, offset zero,
// queue empty.
// ----------------------------------------------------------------------------
// sql_token_scanner
// Byte-serial SQL lexer: input register, one-pass scan logic, result queue.
// ----------------------------------------------------------------------------
`default_nettype none
module sql_token_scanner #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  wire               clk,
  input  wire               rst_n,
  input  wire               in_valid,
  output logic              in_ready,
  input  wire sts_pkg::in_t in_data,
  output logic              out_valid,
  input  wire               out_ready,
  output sts_pkg::out_t     out_data
);

  sts_pkg::in_t           in_buf_r;
  logic                   in_v_r, in_v_nxt;
  sts_pkg::ctl_t          ctl_r, ctl_nxt;
  logic [OFFSET_BITS-1:0] off_r, off_nxt, start_r, start_nxt;
  logic [LENGTH_BITS-1:0] len_r, len_nxt;
  logic [1:0]             nres, push_n;
  sts_pkg::out_t          res0, res1;
  logic                   room2, fire;

  assign fire     = in_v_r && room2;
  assign in_ready = !in_v_r || fire;
  assign in_v_nxt = (in_valid && in_ready) ? 1'b1 : (fire ? 1'b0 : in_v_r);
  assign push_n   = fire ? nres : 2'd0;

  sts_step #(
    .OFFSET_BITS(OFFSET_BITS),
    .LENGTH_BITS(LENGTH_BITS)
  ) u_step (
    .ctl_i  (ctl_r),
    .off_i  (off_r),
    .start_i(start_r),
    .len_i  (len_r),
    .char_i (in_buf_r.char_byte),
    .eof_i  (in_buf_r.end_of_input),
    .ctl_o  (ctl_nxt),
    .start_o(start_nxt),
    .len_o  (len_nxt),
    .nres_o (nres),
    .res0_o (res0),
    .res1_o (res1)
  );

  // advance the offset on every byte, hold it on end of input
  assign off_nxt = in_buf_r.end_of_input ? off_r : off_r + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      ctl_r   <= '{mode: sts_pkg::M_IDLE, pend: sts_pkg::P_NONE,
                   base_is: sts_pkg::B_OCT, base_has: sts_pkg::B_OCT, default: '0};
      off_r   <= '0;
      start_r <= '0;
      len_r   <= '0;
    end else begin
      in_v_r <= in_v_nxt;
      if (fire) begin
        ctl_r   <= ctl_nxt;
        off_r   <= off_nxt;
        start_r <= start_nxt;
        len_r   <= len_nxt;
      end
    end
  end

  // hold the accepted beat
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) in_buf_r <= in_data;
  end

  sts_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push_n   (push_n),
    .push0    (res0),
    .push1    (res1),
    .room2    (room2),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/sts_step.sv -----
// ----------------------------------------------------------------------------
// sts_step
// Next-state and result logic for one source byte or end of input.
// ----------------------------------------------------------------------------
`default_nettype none
module sts_step #(
  parameter int OFFSET_BITS = 32,
  parameter int LENGTH_BITS = 16
) (
  input  wire sts_pkg::ctl_t         ctl_i,
  input  wire [OFFSET_BITS-1:0]      off_i,
  input  wire [OFFSET_BITS-1:0]      start_i,
  input  wire [LENGTH_BITS-1:0]      len_i,
  input  wire [7:0]                  char_i,
  input  wire                        eof_i,
  output sts_pkg::ctl_t              ctl_o,
  output logic [OFFSET_BITS-1:0]     start_o,
  output logic [LENGTH_BITS-1:0]     len_o,
  output logic [1:0]                 nres_o,
  output sts_pkg::out_t              res0_o,
  output sts_pkg::out_t              res1_o
);

  sts_pkg::ctl_t          ctl;
  logic [OFFSET_BITS-1:0] st;
  logic [LENGTH_BITS-1:0] ln;
  logic                   done, grow, em, dig, fnd, skip;
  logic [5:0]             ek;
  logic [4:0]             jf, lim;
  logic [1:0]             n;
  logic [2:0]             cls;
  logic                   mt;
  sts_pkg::base_t         nb_is, nb_has;

  always_comb begin
    ctl   = ctl_i;
    st    = start_i;
    ln    = len_i;
    done  = 1'b0;
    grow  = 1'b0;
    em    = 1'b0;
    ek    = sts_pkg::K_EOF;
    n     = 2'd0;
    fnd   = 1'b0;
    skip  = 1'b0;
    jf    = '0;
    lim   = '0;
    cls   = '0;
    mt    = 1'b0;
    res0_o = '0;
    res1_o = '0;
    dig   = !eof_i && sts_pkg::is_dec(char_i);
    nb_is  = (ctl_i.base_is == sts_pkg::B_OCT) ? sts_pkg::B_DEC : ctl_i.base_is;
    nb_has = (ctl_i.base_has == sts_pkg::B_OCT) ? sts_pkg::B_DEC : ctl_i.base_has;

    // rewrite modes that hand the byte on without a result
    case (ctl.mode)
      sts_pkg::M_PUNCT: begin
        if (ctl.pend == sts_pkg::P_DOT && dig) begin
          ctl.mode = sts_pkg::M_FRAC;
          ctl.pend = sts_pkg::P_NONE;
          ctl.base_is = sts_pkg::B_DEC;
          ctl.base_has = sts_pkg::B_DEC;
          ctl.empty = 1'b1;
          ctl.flt = 1'b1;
        end
      end
      sts_pkg::M_ZERO: begin
        ctl.mode = sts_pkg::M_INT;
        if (!eof_i && (char_i == "x" || char_i == "X")) begin
          grow = 1'b1;
          ctl.empty = 1'b1;
          ctl.base_is = sts_pkg::B_HEX;
          ctl.base_has = sts_pkg::B_HEX;
          done = 1'b1;
        end
      end
      sts_pkg::M_EXPSIGN: begin
        ctl.mode = sts_pkg::M_EXPDIG;
        if (!eof_i && (char_i == "-" || char_i == "+")) begin
          grow = 1'b1;
          done = 1'b1;
        end
      end
      default: ;
    endcase

    // handle the byte in the current token mode
    if (!done) begin
      case (ctl.mode)
        sts_pkg::M_PUNCT: begin
          if (ctl.pend == sts_pkg::P_MINUS) begin
            if (!eof_i && char_i == "-") begin
              ctl.mode = sts_pkg::M_COMMENT;
              ctl.pend = sts_pkg::P_NONE;
              done = 1'b1;
            end else begin
              em = 1'b1; ek = sts_pkg::K_MINUS;
            end
          end else if (ctl.pend == sts_pkg::P_DOT) begin
            if (!eof_i && char_i == ".") begin
              grow = 1'b1; em = 1'b1; ek = sts_pkg::K_DOTDOT; done = 1'b1;
            end else begin
              em = 1'b1; ek = sts_pkg::K_DOT;
            end
          end else if (!eof_i && char_i == "=") begin
            grow = 1'b1; em = 1'b1; done = 1'b1;
            ek = (ctl.pend == sts_pkg::P_LT) ? sts_pkg::K_LE :
                 (ctl.pend == sts_pkg::P_GT) ? sts_pkg::K_GE : sts_pkg::K_NE;
          end else begin
            em = 1'b1;
            ek = (ctl.pend == sts_pkg::P_LT) ? sts_pkg::K_LT :
                 (ctl.pend == sts_pkg::P_GT) ? sts_pkg::K_GT : sts_pkg::K_ILLEGAL;
          end
        end
        sts_pkg::M_COMMENT: begin
          if (eof_i) begin
            ctl.mode = sts_pkg::M_IDLE;
          end else begin
            if (char_i == 8'h0A) ctl.mode = sts_pkg::M_IDLE;
            done = 1'b1;
          end
        end
        sts_pkg::M_IDENT: begin
          if (ctl.ident_d && !eof_i && char_i == "'") begin
            ctl.ident_d = 1'b0;
            grow = 1'b1;
            ctl.mode = sts_pkg::M_DATE;
            ctl.dstep = '0;
            ctl.inv = 1'b0;
            ctl.dt = 1'b0;
            done = 1'b1;
          end else begin
            ctl.ident_d = 1'b0;
            if (!eof_i && (char_i == "_" || sts_pkg::is_alpha(char_i) ||
                           sts_pkg::is_dec(char_i))) begin
              grow = 1'b1; done = 1'b1;
            end else begin
              em = 1'b1; ek = sts_pkg::K_IDENT;
            end
          end
        end
        sts_pkg::M_INT, sts_pkg::M_FRAC, sts_pkg::M_EXPDIG: begin
          if ((ctl.mode == sts_pkg::M_EXPDIG && dig) ||
              (ctl.mode != sts_pkg::M_EXPDIG && ctl.base_is != sts_pkg::B_HEX && dig) ||
              (ctl.mode != sts_pkg::M_EXPDIG && ctl.base_is == sts_pkg::B_HEX &&
               !eof_i && sts_pkg::is_hex(char_i))) begin
            // extend the digit run
            if (ctl.mode == sts_pkg::M_INT && ctl.base_is == sts_pkg::B_OCT &&
                !sts_pkg::is_oct(char_i))
              ctl.base_has = sts_pkg::B_DEC;
            ctl.empty = 1'b0;
            grow = 1'b1;
            done = 1'b1;
          end else if (ctl.mode == sts_pkg::M_INT && !eof_i && char_i == ".") begin
            grow = 1'b1;
            ctl.flt = 1'b1;
            ctl.base_is = nb_is;
            ctl.base_has = nb_has;
            ctl.mode = sts_pkg::M_FRAC;
            done = 1'b1;
          end else if (ctl.mode != sts_pkg::M_EXPDIG && !eof_i &&
                       ((ctl.base_is != sts_pkg::B_HEX && (char_i == "e" || char_i == "E")) ||
                        (ctl.base_is == sts_pkg::B_HEX && (char_i == "p" || char_i == "P")))) begin
            grow = 1'b1;
            ctl.flt = 1'b1;
            ctl.empty = 1'b1;
            ctl.base_is = nb_is;
            ctl.base_has = nb_has;
            ctl.mode = sts_pkg::M_EXPSIGN;
            done = 1'b1;
          end else begin
            // close the number
            em = 1'b1;
            if (ctl.empty || ctl.base_is != ctl.base_has) ek = sts_pkg::K_BADNUM;
            else if (ctl.base_is == sts_pkg::B_OCT) ek = sts_pkg::K_OCT;
            else if (ctl.base_is == sts_pkg::B_DEC)
              ek = ctl.flt ? sts_pkg::K_DFLOAT : sts_pkg::K_DEC;
            else ek = ctl.flt ? sts_pkg::K_HFLOAT : sts_pkg::K_HEX;
          end
        end
        sts_pkg::M_STR: begin
          if (eof_i) begin
            em = 1'b1; ek = sts_pkg::K_UNTSTR;
          end else begin
            grow = 1'b1;
            done = 1'b1;
            if (char_i == "\"") begin
              em = 1'b1; ek = ctl.inv ? sts_pkg::K_BADESC : sts_pkg::K_STRING;
            end else if (char_i == "\\") begin
              ctl.mode = sts_pkg::M_STRESC;
            end
          end
        end
        sts_pkg::M_STRESC: begin
          if (eof_i) begin
            em = 1'b1; ek = sts_pkg::K_UNTSTR;
          end else begin
            if (char_i != "\"" && char_i != "\\" && char_i != "n" && char_i != "t")
              ctl.inv = 1'b1;
            grow = 1'b1;
            ctl.mode = sts_pkg::M_STR;
            done = 1'b1;
          end
        end
        sts_pkg::M_DATE: begin
          // find the first slot from here that takes the byte
          lim = (ctl.dstep <= 5'(sts_pkg::DATE_SPLIT)) ? 5'(sts_pkg::DATE_SPLIT) : 5'd19;
          if (ctl.dstep < sts_pkg::DATE_CLOSE) begin
            for (int j = 0; j < sts_pkg::DATE_SLOTS - 1; j++) begin
              cls = sts_pkg::date_slot(5'(j));
              mt = !eof_i &&
                   (((cls == sts_pkg::S_OPTDASH || cls == sts_pkg::S_DASH) && char_i == "-") ||
                    (cls == sts_pkg::S_DIGIT && sts_pkg::is_dec(char_i)) ||
                    (cls == sts_pkg::S_COLON && char_i == ":") ||
                    (cls == sts_pkg::S_SPACE && char_i == " "));
              if (!fnd && 5'(j) >= ctl.dstep && 5'(j) <= lim) begin
                if (mt) begin
                  fnd = 1'b1;
                  jf = 5'(j);
                end else if (cls == sts_pkg::S_DIGIT || cls == sts_pkg::S_DASH ||
                             cls == sts_pkg::S_COLON) begin
                  skip = 1'b1;
                end
              end
            end
          end
          if (skip) ctl.inv = 1'b1;
          if (fnd) begin
            grow = 1'b1;
            ctl.dstep = jf + 5'd1;
            if (jf == 5'(sts_pkg::DATE_SPLIT)) ctl.dt = 1'b1;
            done = 1'b1;
          end else begin
            ctl.dstep = sts_pkg::DATE_CLOSE;
            if (!eof_i && char_i == "'") begin
              grow = 1'b1; em = 1'b1; done = 1'b1;
              ek = ctl.inv ? sts_pkg::K_BADDATE :
                   (ctl.dt ? sts_pkg::K_DATETIME : sts_pkg::K_DATE);
            end else begin
              em = 1'b1; ek = sts_pkg::K_UNTDATE;
            end
          end
        end
        sts_pkg::M_INSTR: begin
          if (eof_i || char_i == ";") begin
            em = 1'b1; ek = sts_pkg::K_INSTR;
          end else begin
            grow = 1'b1; done = 1'b1;
          end
        end
        default: ctl.mode = sts_pkg::M_IDLE;
      endcase
    end

    // grow the length, saturating
    if (grow && ln != {LENGTH_BITS{1'b1}}) ln = ln + 1'b1;

    // report the token closed in this mode
    if (em) begin
      res0_o = '{token_kind: ek, start_offset: 32'(st), token_length: 16'(ln),
                 last_of_run: 1'b0};
      n = 2'd1;
      ctl.mode = sts_pkg::M_IDLE;
      ctl.pend = sts_pkg::P_NONE;
      ctl.ident_d = 1'b0;
    end

    // scan the byte again from idle
    em = 1'b0;
    if (!done) begin
      ctl.mode = sts_pkg::M_IDLE;
      if (eof_i) begin
        st = off_i; ln = '0; em = 1'b1; ek = sts_pkg::K_EOF;
      end else begin
        case (char_i)
          8'h20, 8'h09, 8'h0B, 8'h0C, 8'h0A, 8'h0D: ;
          default: begin
            st = off_i;
            ln = LENGTH_BITS'(1);
            case (char_i)
              "(": begin em = 1'b1; ek = sts_pkg::K_LPAREN;  end
              ")": begin em = 1'b1; ek = sts_pkg::K_RPAREN;  end
              "~": begin em = 1'b1; ek = sts_pkg::K_TILDE;   end
              "+": begin em = 1'b1; ek = sts_pkg::K_PLUS;    end
              "*": begin em = 1'b1; ek = sts_pkg::K_STAR;    end
              "/": begin em = 1'b1; ek = sts_pkg::K_SLASH;   end
              "%": begin em = 1'b1; ek = sts_pkg::K_PERCENT; end
              "=": begin em = 1'b1; ek = sts_pkg::K_EQ;      end
              ",": begin em = 1'b1; ek = sts_pkg::K_COMMA;   end
              ";": begin em = 1'b1; ek = sts_pkg::K_SEMI;    end
              "-": begin ctl.mode = sts_pkg::M_PUNCT; ctl.pend = sts_pkg::P_MINUS; end
              "<": begin ctl.mode = sts_pkg::M_PUNCT; ctl.pend = sts_pkg::P_LT;    end
              ">": begin ctl.mode = sts_pkg::M_PUNCT; ctl.pend = sts_pkg::P_GT;    end
              "!": begin ctl.mode = sts_pkg::M_PUNCT; ctl.pend = sts_pkg::P_BANG;  end
              ".": begin ctl.mode = sts_pkg::M_PUNCT; ctl.pend = sts_pkg::P_DOT;   end
              "\"": begin ctl.mode = sts_pkg::M_STR; ctl.inv = 1'b0; end
              "\\": ctl.mode = sts_pkg::M_INSTR;
              "0": begin
                ctl.mode = sts_pkg::M_ZERO;
                ctl.base_is = sts_pkg::B_OCT; ctl.base_has = sts_pkg::B_OCT;
                ctl.empty = 1'b0; ctl.flt = 1'b0;
              end
              default: begin
                if (sts_pkg::is_dec(char_i)) begin
                  ctl.mode = sts_pkg::M_INT;
                  ctl.base_is = sts_pkg::B_DEC; ctl.base_has = sts_pkg::B_DEC;
                  ctl.empty = 1'b0; ctl.flt = 1'b0;
                end else if (char_i == "_" || sts_pkg::is_alpha(char_i)) begin
                  ctl.mode = sts_pkg::M_IDENT;
                  ctl.ident_d = (char_i == "d");
                end else begin
                  em = 1'b1; ek = sts_pkg::K_ILLEGAL;
                end
              end
            endcase
          end
        endcase
      end
    end

    if (em) begin
      if (n == 2'd0)
        res0_o = '{token_kind: ek, start_offset: 32'(st), token_length: 16'(ln),
                   last_of_run: 1'b0};
      else
        res1_o = '{token_kind: ek, start_offset: 32'(st), token_length: 16'(ln),
                   last_of_run: 1'b0};
      n = n + 2'd1;
      ctl.mode = sts_pkg::M_IDLE;
      ctl.pend = sts_pkg::P_NONE;
      ctl.ident_d = 1'b0;
    end

    // mark the last result of this beat
    if (n == 2'd1) res0_o.last_of_run = 1'b1;
    if (n == 2'd2) res1_o.last_of_run = 1'b1;

    ctl_o   = ctl;
    start_o = st;
    len_o   = ln;
    nres_o  = n;
  end

endmodule
`default_nettype wire

// ----- rtl/sts_fifo.sv -----
// ----------------------------------------------------------------------------
// sts_fifo
// Result queue: takes up to two results a cycle, hands out one a cycle while out_ready is high.
// ----------------------------------------------------------------------------
`default_nettype none
module sts_fifo (
  input  wire                clk,
  input  wire                rst_n,
  input  wire [1:0]          push_n,
  input  wire sts_pkg::out_t push0,
  input  wire sts_pkg::out_t push1,
  output logic               room2,
  output logic               out_valid,
  input  wire                out_ready,
  output sts_pkg::out_t      out_data
);

  sts_pkg::out_t mem_r [sts_pkg::FIFO_DEPTH];
  logic [1:0] head_r, head_nxt, tail_r, tail_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       pop;

  assign out_valid = (cnt_r != 3'd0);
  assign out_data  = mem_r[head_r];
  assign room2     = (cnt_r <= 3'd2);
  assign pop       = out_valid && out_ready;

  // advance pointers and count
  always_comb begin
    head_nxt = head_r + {1'b0, pop};
    tail_nxt = tail_r + push_n;
    cnt_nxt  = cnt_r + {1'b0, push_n} - {2'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= '0;
      tail_r <= '0;
      cnt_r  <= '0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // write pushed beats
  always_ff @(posedge clk) begin
    if (push_n != 2'd0) mem_r[tail_r] <= push0;
    if (push_n == 2'd2) mem_r[tail_r + 2'd1] <= push1;
  end

endmodule
`default_nettype wire
